// File: hdl/sgf_pkg.sv
`default_nettype none

package sgf_pkg;

  // segment table and fade sizes
  localparam int MAX_SEGMENTS = 64;
  localparam int FADE_LEN     = 192;

  localparam int PTR_W  = $clog2(MAX_SEGMENTS);
  localparam int STEP_W = (FADE_LEN > 1) ? $clog2(FADE_LEN + 1) : 1;

  // stream payload widths
  localparam int S_TDATA_W = 120;
  localparam int M_TDATA_W = 32;
  localparam int GAIN_W    = 13;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_TAG = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LAG      = CFG_IDX_W'(1);
  localparam logic [19:0] LAG_RST = 20'd48000;

  // gain arithmetic: out = trunc(sample * step * 32767 / (32768 * FADE_LEN))
  localparam int P1W = 16 + STEP_W + 1;
  localparam int P2W = P1W + 15;
  // magnitude after the divide by 32768, at most 32767 * FADE_LEN
  localparam int XW  = $clog2(32767 * FADE_LEN + 1);
  localparam int DL  = $clog2(FADE_LEN);
  // reciprocal of FADE_LEN, exact floor for every x below 2**XW
  localparam int RK  = XW + DL;
  localparam int MW  = RK - DL + 2;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RK) + 64'(FADE_LEN) - 64'd1) / 64'(FADE_LEN);
  localparam logic [MW-1:0] RECIP_M = RECIP_FULL[MW-1:0];
  localparam int PW  = XW + MW;

  typedef struct packed {
    logic [1:0]  seg_tag;
    logic [31:0] seg_finish;
    logic [31:0] seg_begin;
  } seg_entry_t;

endpackage

`default_nettype wire

// File: hdl/sgf_ram.sv
`default_nettype none

module sgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/segment_gate_with_fade_top.sv
`default_nettype none

// Segment gate with fade. Items on the s side are either an append (tuser = 1),
// which adds a segment (begin, one-past-end, 2-bit cluster tag) to a table of at
// most MAX_SEGMENTS-1 entries, dropping the oldest when it is full, or an audio
// sample (tuser = 0), which gives exactly one item on the m side. For a sample the
// analyzed position is position - lag (0 when it would go negative); the table
// is scanned oldest first and the first segment with begin <= pos < end decides:
// the gate opens if its tag equals pass_tag, otherwise (or with no hit) it stays
// closed. The gain step moves one toward FADE_LEN (open) or toward 0 (closed) per
// sample, and the output is trunc(sample*step*32767/(32768*FADE_LEN)) computed
// exactly in integers. An append leaves s_tready high, so the next item can
// follow right away. A sample keeps s_tready low from its acceptance until its
// result is loaded into the output register. The table is scanned first: one
// entry per cycle comes out of the table memory's single read port into the
// shared range compare until the first hit or the end of the fill. Then the
// multiply / reciprocal-divide sequence runs through MUL, SCALE, ABS and RECIP,
// and in FIN the result waits until the output register is free. The result
// sits in an output register, so the next item is taken while it waits on
// m_tready.
// Configuration writes are taken at any cycle (cfg_ready is always high) but
// must only be issued while the block is idle.

module segment_gate_with_fade_top (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample[15:0], position[47:16], seg_begin[79:48], seg_finish[111:80],
  // seg_tag[113:112], zero fill above
  input  logic [sgf_pkg::S_TDATA_W-1:0]    s_tdata,
  // cmd: 0 = audio sample, 1 = append segment
  input  logic                             s_tuser,
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_sample[15:0], gate_open[16], gain_step[29:17], zero fill above
  output logic [sgf_pkg::M_TDATA_W-1:0]    m_tdata,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sgf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import sgf_pkg::*;

  // one-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_SCALE = 7'b0001000,
    ST_ABS   = 7'b0010000,
    ST_RECIP = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_SEGMENTS - 1);
  localparam logic [PTR_W-1:0] COUNT_MAX = PTR_W'(MAX_SEGMENTS - 1);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(FADE_LEN);

  state_t state;

  // configuration registers
  logic [1:0]  pass_tag;
  logic [19:0] lag;

  // segment table bookkeeping (ring buffer)
  logic [PTR_W-1:0] seg_count;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] issued;
  logic             pend;

  // per-sample working registers
  logic [31:0]           apos;
  logic signed [15:0]    smp;
  logic                  open_r;
  logic [STEP_W-1:0]     fade_step;
  logic signed [P1W-1:0] p1;
  logic signed [P2W-1:0] p2;
  logic                  neg;
  logic [XW-1:0]         x;
  logic [PW-1:0]         prod;

  // output register
  logic signed [15:0]  out_sample;
  logic                out_gate;
  logic [GAIN_W-1:0]   out_gain;

  // input fields
  logic [15:0] in_sample;
  logic [31:0] in_position;
  seg_entry_t  in_entry;

  assign in_sample           = s_tdata[15:0];
  assign in_position         = s_tdata[47:16];
  assign in_entry.seg_begin  = s_tdata[79:48];
  assign in_entry.seg_finish = s_tdata[111:80];
  assign in_entry.seg_tag    = s_tdata[113:112];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  logic s_acc;
  logic append_acc;
  logic sample_acc;

  assign s_acc      = s_tvalid && s_tready;
  assign append_acc = s_acc && s_tuser;
  assign sample_acc = s_acc && !s_tuser;

  // table memory
  seg_entry_t rd_entry;
  logic [$bits(seg_entry_t)-1:0] rd_word;

  sgf_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (append_acc),
    .waddr (wr_ptr),
    .wdata (in_entry),
    .raddr (rd_ptr),
    .rdata (rd_word)
  );

  assign rd_entry = seg_entry_t'(rd_word);

  // oldest entry of the ring
  logic [PTR_W:0]   oldest_wide;
  logic [PTR_W-1:0] oldest;

  always_comb begin
    if (wr_ptr >= seg_count) begin
      oldest_wide = {1'b0, wr_ptr} - {1'b0, seg_count};
    end else begin
      oldest_wide = {1'b0, wr_ptr} + (PTR_W+1)'(MAX_SEGMENTS) - {1'b0, seg_count};
    end
    oldest = oldest_wide[PTR_W-1:0];
  end

  // analyzed position, floored at zero
  logic [31:0] apos_in;
  assign apos_in = (in_position >= {12'd0, lag}) ?
                   in_position - {12'd0, lag} : 32'd0;

  // shared range compare against the entry coming out of the memory
  logic hit;
  logic scan_done;
  logic open_now;
  logic [STEP_W-1:0] step_next;

  assign hit       = pend && (apos >= rd_entry.seg_begin) && (apos < rd_entry.seg_finish);
  assign scan_done = hit || ((issued == seg_count) && !pend);
  assign open_now  = hit && (rd_entry.seg_tag == pass_tag);

  always_comb begin
    if (open_now) begin
      step_next = (fade_step < STEP_MAX) ? fade_step + STEP_W'(1) : fade_step;
    end else begin
      step_next = (fade_step != '0) ? fade_step - STEP_W'(1) : fade_step;
    end
  end

  // magnitude and final quotient
  logic [P2W-1:0] p2_mag;
  logic [15:0]    q;
  logic [15:0]    q_signed;

  assign p2_mag   = p2[P2W-1] ? P2W'(-p2) : P2W'(p2);
  assign q        = prod[RK +: 16];
  assign q_signed = neg ? 16'(-q) : q;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_tag <= 2'd0;
      lag      <= LAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PASS_TAG: pass_tag <= cfg_data[1:0];
        REG_LAG:      lag      <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_count <= '0;
      wr_ptr    <= '0;
      fade_step <= '0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (append_acc) begin
            // full ring overwrites the oldest entry, fill stays put
            wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
            if (seg_count != COUNT_MAX) begin
              seg_count <= seg_count + PTR_W'(1);
            end
          end else if (sample_acc) begin
            rd_ptr <= oldest;
            issued <= '0;
            pend   <= 1'b0;
            state  <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (scan_done) begin
            open_r    <= open_now;
            fade_step <= step_next;
            state     <= ST_MUL;
          end else if (issued != seg_count) begin
            rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
            issued <= issued + PTR_W'(1);
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end

        ST_MUL: begin
          state <= ST_SCALE;
        end

        ST_SCALE: begin
          state <= ST_ABS;
        end

        ST_ABS: begin
          state <= ST_RECIP;
        end

        ST_RECIP: begin
          state <= ST_FIN;
        end

        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result valid: set when a finished sample is loaded, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      smp  <= $signed(in_sample);
      apos <= apos_in;
    end
    if (state == ST_MUL) begin
      p1 <= smp * $signed({1'b0, fade_step});
    end
    if (state == ST_SCALE) begin
      // times 32767 as a shift and subtract
      p2 <= (P2W'(p1) <<< 15) - P2W'(p1);
    end
    if (state == ST_ABS) begin
      neg <= p2[P2W-1];
      x   <= p2_mag[15 +: XW];
    end
    if (state == ST_RECIP) begin
      // divide by FADE_LEN through the reciprocal
      prod <= PW'(x) * PW'(RECIP_M);
    end
    if ((state == ST_FIN) && out_free) begin
      out_sample <= $signed(q_signed);
      out_gate   <= open_r;
      out_gain   <= GAIN_W'(fade_step);
    end
  end

  assign m_tdata = {{(M_TDATA_W - 16 - 1 - GAIN_W){1'b0}}, out_gain, out_gate, out_sample};

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sgf_pkg::*;

  // expected gate behavior: own copy of the segment table, the fade position
  // and both registers, plus the results still waiting to come out
  class fade_gate_scoreboard;
    typedef struct {
      logic signed [15:0] out_sample;
      logic               gate_open;
      logic [GAIN_W-1:0]  gain_step;
    } gate_result_t;

    seg_entry_t    seg_table[$];
    logic [1:0]    target = 2'd0;
    logic [19:0]   delay = LAG_RST;
    int unsigned   fade_pos = 0;
    gate_result_t  pending_outputs[$];
    int            errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PASS_TAG: target = val[1:0];
        REG_LAG: delay = val[19:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    // note an accepted item and work out what it produces
    function void note_item(logic is_append, logic [S_TDATA_W-1:0] d);
      seg_entry_t   e;
      logic [31:0]  pos;
      logic [31:0]  apos;
      logic         hit;
      logic         open;
      longint       prod;
      gate_result_t r;
      if (is_append) begin
        e.seg_begin  = d[79:48];
        e.seg_finish = d[111:80];
        e.seg_tag    = d[113:112];
        seg_table.push_back(e);
        if (seg_table.size() >= MAX_SEGMENTS) void'(seg_table.pop_front());
        return;
      end
      pos  = d[47:16];
      apos = (pos >= {12'd0, delay}) ? pos - {12'd0, delay} : 32'd0;
      hit  = 1'b0;
      open = 1'b0;
      foreach (seg_table[i]) begin
        if (!hit && apos >= seg_table[i].seg_begin && apos < seg_table[i].seg_finish) begin
          hit  = 1'b1;
          open = (seg_table[i].seg_tag == target);
        end
      end
      if (open) begin
        if (fade_pos < FADE_LEN) fade_pos++;
      end else begin
        if (fade_pos > 0) fade_pos--;
      end
      prod = longint'($signed(d[15:0])) * longint'(fade_pos) * 64'sd32767;
      prod = prod / (64'sd32768 * longint'(FADE_LEN));
      r.out_sample = prod[15:0];
      r.gate_open  = open;
      r.gain_step  = GAIN_W'(fade_pos);
      pending_outputs.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d);
      gate_result_t want;
      if (pending_outputs.size() == 0) begin
        $error("result item with nothing expected: %h", d);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      if (d[15:0] !== want.out_sample) begin
        $error("out_sample: expected %0d, actual %0d", want.out_sample, $signed(d[15:0]));
        errors++;
      end
      if (d[16] !== want.gate_open) begin
        $error("gate_open: expected %0d, actual %0d", want.gate_open, d[16]);
        errors++;
      end
      if (d[29:17] !== want.gain_step) begin
        $error("gain_step: expected %0d, actual %0d", want.gain_step, d[29:17]);
        errors++;
      end
    endfunction
  endclass

  typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  // register indexes past the list, the block must drop these writes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = {CFG_IDX_W{1'b1}};

  localparam int     PHASE_ITEMS  = 40;   // random items per phase before it may end
  localparam int     DRAIN_CYCLES = 100;  // longer than a full table scan plus the gain math
  localparam int     HOLD_CYCLES  = 400;  // long receiver hold-off to back the block up
  localparam int     IDLE_PCT     = 47;
  localparam int     BOTH_PCT     = 6;
  localparam longint TIMEOUT_NS   = 5_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fade_gate_scoreboard sb = new;

  // stimulus steering: mirror of what was last written, only to aim positions
  logic [1:0]  cur_target = 2'd0;
  logic [19:0] cur_delay = LAG_RST;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          n_sent = 0;

  // receiver hold-off, counted in the receiver's own process
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  segment_gate_with_fade_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check each accepted item, then pick the next tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // tdata packing, lowest field first
  function automatic logic [S_TDATA_W-1:0] pack_sample(logic [15:0] smp, logic [31:0] pos);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[15:0]  = smp;
    d[47:16] = pos;
    return d;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_append(logic [31:0] b, logic [31:0] f,
                                                       logic [1:0] tag);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[79:48]   = b;
    d[111:80]  = f;
    d[113:112] = tag;
    return d;
  endfunction

  // full-scale values show up now and then
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly inside the current region, some below the delay, a few anywhere
  function automatic logic [31:0] pick_position(logic [31:0] base, int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 32'($urandom_range(0, cur_delay));
    if (r < 12) return $urandom;
    return base + {12'd0, cur_delay} + 32'($urandom_range(0, span));
  endfunction

  // offer one item, with random idle cycles in front of it
  task automatic send_item(input logic is_append, input logic [S_TDATA_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= is_append;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_item(is_append, d);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every result, then let a trailing append finish inside the block
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase(input logic [1:0] tgt, input logic [19:0] dly, input idle_mode_e mode);
    write_reg(REG_PASS_TAG, CFG_DATA_W'(tgt));
    write_reg(REG_LAG, dly);
    cur_target   = tgt;
    cur_delay    = dly;
    tx_idle_pct  = (mode == IDLE_TX) ? IDLE_PCT : (mode == IDLE_BOTH) ? BOTH_PCT : 0;
    rx_stall_pct <= (mode == IDLE_RX) ? IDLE_PCT : (mode == IDLE_BOTH) ? BOTH_PCT : 0;
  endtask

  // segment near the region, sometimes empty or inverted, sometimes anywhere
  task automatic send_segment(input logic [31:0] base);
    logic [31:0] b;
    logic [31:0] f;
    logic [1:0]  tag;
    tag = ($urandom_range(1) == 0) ? cur_target : 2'($urandom_range(3));
    if ($urandom_range(99) < 8) begin
      b = $urandom;
      f = $urandom;
      // wide random segments would shadow everything after them, so flip those
      if (f > b && f - b > 32'd100000) {b, f} = {f, b};
    end else begin
      b = base + 32'($urandom_range(0, 3000));
      f = ($urandom_range(9) == 0) ? b - 32'($urandom_range(0, 40))
                                   : b + 32'($urandom_range(1, 1500));
    end
    send_item(1'b1, pack_append(b, f, tag));
  endtask

  // a few appends into a region, then samples aimed at it; a long open run
  // first drives the fade all the way up and lets it come back down
  task automatic run_burst(input bit long_open);
    logic [31:0]          base;
    logic [S_TDATA_W-1:0] d;
    int                   n_app;
    int                   n_smp;
    base = ($urandom_range(3) == 0) ? 32'($urandom_range(0, 5000))
                                    : 32'($urandom_range(0, 32'hffe0_0000));
    if (long_open) begin
      send_item(1'b1, pack_append(base, base + 32'd2500, cur_target));
      repeat (200) begin
        send_item(1'b0, pack_sample(pick_sample(),
                                    base + {12'd0, cur_delay} + 32'($urandom_range(0, 2499))));
      end
    end
    n_app = $urandom_range(0, 4);
    n_smp = $urandom_range(1, 30);
    repeat (n_app) send_segment(base);
    repeat (n_smp) begin
      if ($urandom_range(19) == 0) begin
        // junk everywhere, unused fields included
        d = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[S_TDATA_W-1:114] = '0;
        send_item(1'b0, d);
      end else begin
        send_item(1'b0, pack_sample(pick_sample(), pick_position(base, 4500)));
      end
    end
  endtask

  initial begin
    int phase_start;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values of both registers, empty table
    send_item(1'b0, pack_sample(16'h1234, 32'd48010));
    drain();

    // target 1, delay 100; writes past the register list must change nothing
    set_phase(2'd1, 20'd100, IDLE_NONE);
    write_reg(REG_SPARE, '1);
    write_reg(REG_LAST, '1);

    send_item(1'b0, pack_sample(16'h7fff, 32'd0));              // empty table, below delay
    send_item(1'b1, pack_append(32'd0, 32'd50, 2'd1));
    send_item(1'b1, pack_append(32'd0, 32'd100, 2'd2));         // overlaps, newer
    send_item(1'b1, pack_append(32'd200, 32'd200, 2'd1));       // empty segment
    send_item(1'b1, pack_append(32'd300, 32'd250, 2'd1));       // inverted segment
    send_item(1'b1, pack_append(32'hffff_fe00, 32'hffff_ffff, 2'd3));
    send_item(1'b0, pack_sample(16'h7fff, 32'd5));              // floored to 0, opens
    send_item(1'b0, pack_sample(16'h8000, 32'd130));
    send_item(1'b0, pack_sample(16'hffff, 32'd140));
    send_item(1'b0, pack_sample(16'h7fff, 32'd160));            // only the newer overlap hits
    send_item(1'b0, pack_sample(16'h8000, 32'd300));            // empty segment never hits
    send_item(1'b0, pack_sample(16'h7fff, 32'd360));            // inverted never hits
    send_item(1'b0, pack_sample(16'h8000, 32'hffff_ffff));      // top of range, other tag
    send_item(1'b0, pack_sample(16'h0000, 32'd120));

    // fill past the table size so the oldest entries drop out
    for (int i = 0; i < 70; i++) begin
      send_item(1'b1, pack_append(32'd1000 + 32'(10 * i), 32'd1010 + 32'(10 * i), 2'(i)));
    end
    for (int i = 0; i < 12; i++) begin
      send_item(1'b0, pack_sample(pick_sample(), 32'd1105 + 32'(10 * i)));
    end

    // random phases: register extremes, every idling mode, one long hold-off
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: set_phase(2'd3, 20'd0, IDLE_NONE);
        1: set_phase(2'd0, 20'hfffff, IDLE_TX);
        2: set_phase(2'($urandom_range(3)), 20'($urandom), IDLE_RX);
        3: set_phase(2'd2, 20'd48000, IDLE_BOTH);
        default: begin
          set_phase(2'($urandom_range(3)), 20'($urandom_range(0, 200)), IDLE_NONE);
          hold_armed <= 1'b1;
        end
      endcase
      phase_start = n_sent;
      run_burst(p == 0);
      while (n_sent - phase_start < PHASE_ITEMS) run_burst(1'b0);
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
